>>> rtl/bspce_pkg.sv
// Shared types, sequencer codes and saturation helper for the B-spline point evaluator.
// Used by bspce_ctrl, bspce_dp and the top level; no dependencies of its own.
`default_nettype none
package bspce_pkg;

  localparam int DATA_W       = 32;
  localparam int SAT_W        = 72;
  localparam int SEARCH_LIMIT = 64;
  localparam int STEP_W       = 7;

  localparam logic [1:0] FUNC_LOAD_KNOT  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_POINT = 2'd1;
  localparam logic [1:0] FUNC_EVAL       = 2'd2;

  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_NUM_CP = 1'b1;

  typedef logic [4:0] op_t;

  localparam op_t ST_IDLE = 5'd0;
  localparam op_t ST_CHK0 = 5'd1;
  localparam op_t ST_CHK1 = 5'd2;
  localparam op_t ST_CHK2 = 5'd3;
  localparam op_t ST_SR0  = 5'd4;
  localparam op_t ST_SR1  = 5'd5;
  localparam op_t ST_SR2  = 5'd6;
  localparam op_t ST_LR0  = 5'd7;
  localparam op_t ST_LR1  = 5'd8;
  localparam op_t ST_LR2  = 5'd9;
  localparam op_t ST_DIV0 = 5'd10;
  localparam op_t ST_DIV1 = 5'd11;
  localparam op_t ST_MUL1 = 5'd12;
  localparam op_t ST_MUL2 = 5'd13;
  localparam op_t ST_MUL3 = 5'd14;
  localparam op_t ST_AC0  = 5'd15;
  localparam op_t ST_AC1  = 5'd16;
  localparam op_t ST_AC2  = 5'd17;
  localparam op_t ST_AC3  = 5'd18;
  localparam op_t ST_AC4  = 5'd19;
  localparam op_t ST_FAIL = 5'd20;
  localparam op_t ST_FIN  = 5'd21;

  typedef struct packed {
    op_t  op;
    logic eval_start;
    logic load_knot;
    logic load_point;
  } cmd_t;

  typedef struct packed {
    logic bad_count;
    logic u_lt;
    logic u_gt;
    logic u_eq;
    logic hit;
    logic steps_max;
    logic span_bad;
    logic den_zero;
    logic div_done;
    logic r_last;
    logic j_last;
    logic out_free;
  } stat_t;

  localparam logic signed [SAT_W-1:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -72'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [DATA_W-1:0] res;
    if (x > SAT_MAX) begin
      res = 32'sh7fffffff;
    end else if (x < SAT_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = x[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bspce_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturation to 32 bits.
// Divides a Q-format value shifted up by FRAC_BITS; uses no package items.
`default_nettype none
module bspce_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [32:0] den,
  output logic                    done,
  output logic signed [31:0]      quo
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam int RW = 34;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic [32:0]   dsr_r;
  logic          neg_r;

  logic [31:0]   num_mag;
  logic [32:0]   den_mag;
  logic [RW-1:0] rem_sh;
  logic          ge;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign rem_sh  = {rem_r[RW-2:0], q_r[QW-1]};
  assign ge      = rem_sh >= RW'(dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= {num_mag, FRAC_BITS'(0)};
      dsr_r <= den_mag;
      rem_r <= '0;
      neg_r <= num[31] ^ den[32];
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - RW'(dsr_r)) : rem_sh;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  always_comb begin
    if (!neg_r) begin
      quo = (|q_r[QW-1:31]) ? 32'sh7fffffff : $signed({1'b0, q_r[30:0]});
    end else begin
      quo = (|q_r[QW-1:31]) ? 32'sh80000000 : $signed(-{1'b0, q_r[30:0]});
    end
  end

  assign done = done_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_busy_progress: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (busy_r || done_r))
    else $error("divider stopped without done");

endmodule
`default_nettype wire

>>> rtl/bspce_ctrl.sv
// Sequencer for the evaluator: span check, span search, basis recurrence, weighted sum.
// Depends on bspce_pkg for state codes and the command and status structs.
`default_nettype none
module bspce_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic [1:0]       in_func,
  input  wire bspce_pkg::stat_t stat,
  output logic                  in_tready,
  output bspce_pkg::cmd_t       cmd
);

  bspce_pkg::op_t state_r;
  bspce_pkg::op_t state_nxt;
  logic           accept;

  assign in_tready = (state_r == bspce_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.op         = state_r;
    cmd.eval_start = accept && (in_func == bspce_pkg::FUNC_EVAL);
    cmd.load_knot  = accept && (in_func == bspce_pkg::FUNC_LOAD_KNOT);
    cmd.load_point = accept && (in_func == bspce_pkg::FUNC_LOAD_POINT);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bspce_pkg::ST_IDLE: begin
        if (cmd.eval_start) state_nxt = bspce_pkg::ST_CHK0;
      end
      bspce_pkg::ST_CHK0: state_nxt = stat.bad_count ? bspce_pkg::ST_FAIL : bspce_pkg::ST_CHK1;
      bspce_pkg::ST_CHK1: state_nxt = stat.u_lt ? bspce_pkg::ST_FAIL : bspce_pkg::ST_CHK2;
      bspce_pkg::ST_CHK2: begin
        if (stat.u_gt) state_nxt = bspce_pkg::ST_FAIL;
        else if (stat.u_eq) state_nxt = bspce_pkg::ST_LR0;
        else state_nxt = bspce_pkg::ST_SR0;
      end
      bspce_pkg::ST_SR0: state_nxt = bspce_pkg::ST_SR1;
      bspce_pkg::ST_SR1: state_nxt = bspce_pkg::ST_SR2;
      bspce_pkg::ST_SR2: begin
        if (stat.hit) begin
          state_nxt = stat.span_bad ? bspce_pkg::ST_FAIL : bspce_pkg::ST_LR0;
        end else begin
          state_nxt = stat.steps_max ? bspce_pkg::ST_FAIL : bspce_pkg::ST_SR0;
        end
      end
      bspce_pkg::ST_LR0:  state_nxt = bspce_pkg::ST_LR1;
      bspce_pkg::ST_LR1:  state_nxt = bspce_pkg::ST_LR2;
      bspce_pkg::ST_LR2:  state_nxt = bspce_pkg::ST_DIV0;
      bspce_pkg::ST_DIV0: state_nxt = stat.den_zero ? bspce_pkg::ST_MUL1 : bspce_pkg::ST_DIV1;
      bspce_pkg::ST_DIV1: begin
        if (stat.div_done) state_nxt = bspce_pkg::ST_MUL1;
      end
      bspce_pkg::ST_MUL1: state_nxt = bspce_pkg::ST_MUL2;
      bspce_pkg::ST_MUL2: state_nxt = bspce_pkg::ST_MUL3;
      bspce_pkg::ST_MUL3: begin
        if (!stat.r_last) state_nxt = bspce_pkg::ST_DIV0;
        else if (stat.j_last) state_nxt = bspce_pkg::ST_AC0;
        else state_nxt = bspce_pkg::ST_LR0;
      end
      bspce_pkg::ST_AC0: state_nxt = bspce_pkg::ST_AC1;
      bspce_pkg::ST_AC1: state_nxt = bspce_pkg::ST_AC2;
      bspce_pkg::ST_AC2: state_nxt = bspce_pkg::ST_AC3;
      bspce_pkg::ST_AC3: state_nxt = bspce_pkg::ST_AC4;
      bspce_pkg::ST_AC4: state_nxt = stat.j_last ? bspce_pkg::ST_FIN : bspce_pkg::ST_AC0;
      bspce_pkg::ST_FAIL: state_nxt = bspce_pkg::ST_FIN;
      bspce_pkg::ST_FIN: begin
        if (stat.out_free) state_nxt = bspce_pkg::ST_IDLE;
      end
      default: state_nxt = bspce_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bspce_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bspce_dp.sv
// Datapath: knot and point memories, search registers, basis arrays, shared multiplier,
// accumulators and the output register. Depends on bspce_pkg and bspce_div.
`default_nettype none
module bspce_dp #(
  parameter int MAX_CONTROL_POINTS = 32,
  parameter int MAX_DEGREE         = 7,
  parameter int FRAC_BITS          = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bspce_pkg::cmd_t    cmd,
  output bspce_pkg::stat_t        stat,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_index,
  input  wire logic [5:0]         cfg_data,
  input  wire logic [5:0]         in_index,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic signed [31:0]      out_curve_x,
  output logic signed [31:0]      out_curve_y,
  output logic signed [31:0]      out_curve_z,
  output logic [4:0]              out_span,
  output logic                    out_of_range
);

  localparam int KD   = MAX_CONTROL_POINTS + MAX_DEGREE + 1;
  localparam int KAW  = $clog2(KD);
  localparam int PAW  = $clog2(MAX_CONTROL_POINTS);
  localparam int PW   = $clog2(MAX_DEGREE + 1);
  localparam int NW   = $clog2(MAX_CONTROL_POINTS + 1);
  localparam int ACCW = 64 - FRAC_BITS + PW + 1;
  localparam int SW   = bspce_pkg::SAT_W;
  localparam int STW  = bspce_pkg::STEP_W;

  logic signed [31:0] knot_mem [KD];
  logic [95:0]        pt_mem [MAX_CONTROL_POINTS];

  logic [2:0]          deg_r;
  logic [5:0]          ncp_r;
  logic signed [31:0]  u_r;
  logic [PW-1:0]       p_r;
  logic [NW-1:0]       n_r;
  logic [NW-1:0]       lo_r;
  logic [NW-1:0]       hi_r;
  logic [NW-1:0]       mid_r;
  logic [STW-1:0]      steps_r;
  logic [NW-1:0]       span_r;
  logic [PW-1:0]       j_r;
  logic [PW-1:0]       r_r;
  logic signed [31:0]  ka_r;
  logic signed [31:0]  knot_rd_r;
  logic [95:0]         pt_rd_r;
  logic signed [31:0]  left_r  [MAX_DEGREE + 1];
  logic signed [31:0]  right_r [MAX_DEGREE + 1];
  logic signed [31:0]  basis_r [MAX_DEGREE + 1];
  logic signed [31:0]  saved_r;
  logic signed [31:0]  temp_r;
  logic signed [63:0]  prod_r;
  logic signed [ACCW-1:0] acc_x_r;
  logic signed [ACCW-1:0] acc_y_r;
  logic signed [ACCW-1:0] acc_z_r;
  logic                err_r;
  logic                out_valid_r;
  logic signed [31:0]  curve_x_r;
  logic signed [31:0]  curve_y_r;
  logic signed [31:0]  curve_z_r;
  logic [4:0]          span_out_r;
  logic                oor_r;

  logic [PW-1:0]       p_cl;
  logic [NW-1:0]       n_cl;
  logic [KAW-1:0]      knot_ra;
  logic [PAW-1:0]      pt_ra;
  logic [PW-1:0]       r1;
  logic [PW-1:0]       jr;
  logic [PW-1:0]       b_addr;
  logic signed [31:0]  right_q;
  logic signed [31:0]  left_q;
  logic signed [31:0]  basis_q;
  logic signed [32:0]  den;
  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [63:0]  mul_p;
  logic signed [63:0]  prod_sh;
  logic signed [31:0]  nb;
  logic signed [31:0]  sv;
  logic                div_start;
  logic                div_done;
  logic signed [31:0]  div_q;
  logic                is_acc;
  logic [NW-1:0]       lo_nx;
  logic [NW-1:0]       hi_nx;

  // Register values outside the supported range are pulled back into it.
  always_comb begin
    if (deg_r == 3'd0) p_cl = PW'(1);
    else if (32'(deg_r) > MAX_DEGREE) p_cl = PW'(MAX_DEGREE);
    else p_cl = PW'(deg_r);
    if (32'(ncp_r) < 2) n_cl = NW'(2);
    else if (32'(ncp_r) > MAX_CONTROL_POINTS) n_cl = NW'(MAX_CONTROL_POINTS);
    else n_cl = NW'(ncp_r);
  end

  always_comb begin
    case (cmd.op)
      bspce_pkg::ST_CHK0: knot_ra = KAW'(p_r);
      bspce_pkg::ST_CHK1: knot_ra = KAW'(n_r);
      bspce_pkg::ST_SR0:  knot_ra = KAW'(mid_r);
      bspce_pkg::ST_SR1:  knot_ra = KAW'(32'(mid_r) + 1);
      bspce_pkg::ST_LR0:  knot_ra = KAW'(32'(span_r) + 1 - 32'(j_r));
      bspce_pkg::ST_LR1:  knot_ra = KAW'(32'(span_r) + 32'(j_r));
      default:            knot_ra = '0;
    endcase
  end

  assign pt_ra   = PAW'(32'(span_r) - 32'(p_r) + 32'(j_r));
  assign r1      = r_r + PW'(1);
  assign jr      = j_r - r_r;
  assign is_acc  = (cmd.op == bspce_pkg::ST_AC1) || (cmd.op == bspce_pkg::ST_AC2) ||
                   (cmd.op == bspce_pkg::ST_AC3);
  assign b_addr  = is_acc ? j_r : r_r;
  assign right_q = right_r[r1];
  assign left_q  = left_r[jr];
  assign basis_q = basis_r[b_addr];
  assign den     = 33'(right_q) + 33'(left_q);

  always_comb begin
    case (cmd.op)
      bspce_pkg::ST_MUL2: begin
        mul_a = left_q;
        mul_b = temp_r;
      end
      bspce_pkg::ST_AC1: begin
        mul_a = basis_q;
        mul_b = $signed(pt_rd_r[31:0]);
      end
      bspce_pkg::ST_AC2: begin
        mul_a = basis_q;
        mul_b = $signed(pt_rd_r[63:32]);
      end
      bspce_pkg::ST_AC3: begin
        mul_a = basis_q;
        mul_b = $signed(pt_rd_r[95:64]);
      end
      default: begin
        mul_a = right_q;
        mul_b = temp_r;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign nb      = bspce_pkg::sat32(SW'(saved_r) + SW'(prod_sh));
  assign sv      = bspce_pkg::sat32(SW'(prod_sh));

  assign lo_nx = (u_r < ka_r) ? lo_r : mid_r;
  assign hi_nx = (u_r < ka_r) ? mid_r : hi_r;

  assign div_start = (cmd.op == bspce_pkg::ST_DIV0) && (den == '0) == 1'b0;

  bspce_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (basis_q),
    .den  (den),
    .done (div_done),
    .quo  (div_q)
  );

  always_comb begin
    stat.bad_count = 32'(n_r) < (32'(p_r) + 1);
    stat.u_lt      = u_r < knot_rd_r;
    stat.u_gt      = u_r > knot_rd_r;
    stat.u_eq      = u_r == knot_rd_r;
    stat.hit       = !((u_r < ka_r) || (u_r >= knot_rd_r));
    stat.steps_max = steps_r == STW'(bspce_pkg::SEARCH_LIMIT);
    stat.span_bad  = (32'(mid_r) < 32'(p_r)) || (32'(mid_r) > (32'(n_r) - 1));
    stat.den_zero  = den == '0;
    stat.div_done  = div_done;
    stat.r_last    = r1 == j_r;
    stat.j_last    = j_r == p_r;
    stat.out_free  = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r       <= 3'd3;
      ncp_r       <= 6'd4;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bspce_pkg::REG_DEGREE: deg_r <= cfg_data[2:0];
          bspce_pkg::REG_NUM_CP: ncp_r <= cfg_data;
          default: ;
        endcase
      end
      if ((cmd.op == bspce_pkg::ST_FIN) && stat.out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    knot_rd_r <= knot_mem[knot_ra];
    pt_rd_r   <= pt_mem[pt_ra];
    if (cmd.load_knot && (32'(in_index) < KD)) begin
      knot_mem[KAW'(in_index)] <= in_value;
    end
    if (cmd.load_point && (32'(in_index) < MAX_CONTROL_POINTS)) begin
      pt_mem[PAW'(in_index)] <= {in_point_z, in_point_y, in_point_x};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      u_r     <= in_value;
      p_r     <= p_cl;
      n_r     <= n_cl;
      err_r   <= 1'b0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end
    case (cmd.op)
      bspce_pkg::ST_CHK2: begin
        // u on the last knot belongs to the final span.
        if (stat.u_eq) begin
          span_r     <= NW'(32'(n_r) - 1);
          j_r        <= PW'(1);
          basis_r[0] <= 32'(64'd1 << FRAC_BITS);
        end else begin
          lo_r    <= NW'(p_r);
          hi_r    <= n_r;
          mid_r   <= NW'((32'(p_r) + 32'(n_r)) >> 1);
          steps_r <= '0;
        end
      end
      bspce_pkg::ST_SR1: ka_r <= knot_rd_r;
      bspce_pkg::ST_SR2: begin
        if (stat.hit) begin
          span_r     <= mid_r;
          j_r        <= PW'(1);
          basis_r[0] <= 32'(64'd1 << FRAC_BITS);
        end else begin
          steps_r <= steps_r + STW'(1);
          lo_r    <= lo_nx;
          hi_r    <= hi_nx;
          mid_r   <= NW'((32'(lo_nx) + 32'(hi_nx)) >> 1);
        end
      end
      bspce_pkg::ST_LR1: left_r[j_r] <= bspce_pkg::sat32(SW'(u_r) - SW'(knot_rd_r));
      bspce_pkg::ST_LR2: begin
        right_r[j_r] <= bspce_pkg::sat32(SW'(knot_rd_r) - SW'(u_r));
        saved_r      <= '0;
        r_r          <= '0;
      end
      bspce_pkg::ST_DIV0: begin
        if (stat.den_zero) temp_r <= '0;
      end
      bspce_pkg::ST_DIV1: begin
        if (div_done) temp_r <= div_q;
      end
      bspce_pkg::ST_MUL1: prod_r <= mul_p;
      bspce_pkg::ST_MUL2: begin
        basis_r[r_r] <= nb;
        prod_r       <= mul_p;
      end
      bspce_pkg::ST_MUL3: begin
        saved_r <= sv;
        if (stat.r_last) begin
          basis_r[j_r] <= sv;
          j_r          <= stat.j_last ? '0 : (j_r + PW'(1));
        end else begin
          r_r <= r1;
        end
      end
      bspce_pkg::ST_AC1: prod_r <= mul_p;
      bspce_pkg::ST_AC2: begin
        acc_x_r <= acc_x_r + ACCW'(prod_sh);
        prod_r  <= mul_p;
      end
      bspce_pkg::ST_AC3: begin
        acc_y_r <= acc_y_r + ACCW'(prod_sh);
        prod_r  <= mul_p;
      end
      bspce_pkg::ST_AC4: begin
        acc_z_r <= acc_z_r + ACCW'(prod_sh);
        if (!stat.j_last) j_r <= j_r + PW'(1);
      end
      bspce_pkg::ST_FAIL: err_r <= 1'b1;
      bspce_pkg::ST_FIN: begin
        if (stat.out_free) begin
          curve_x_r  <= err_r ? '0 : bspce_pkg::sat32(SW'(acc_x_r));
          curve_y_r  <= err_r ? '0 : bspce_pkg::sat32(SW'(acc_y_r));
          curve_z_r  <= err_r ? '0 : bspce_pkg::sat32(SW'(acc_z_r));
          span_out_r <= err_r ? '0 : 5'(span_r);
          oor_r      <= err_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid   = out_valid_r;
  assign out_curve_x  = curve_x_r;
  assign out_curve_y  = curve_y_r;
  assign out_curve_z  = curve_z_r;
  assign out_span     = span_out_r;
  assign out_of_range = oor_r;

endmodule
`default_nettype wire

>>> rtl/bspline_curve_point_evaluator_unit.sv
// B-spline curve point evaluator: loads are written on acceptance and can run back to back.
// An evaluate beat runs the span check, the span search, the basis recurrence and the weighted
// sum before its result reaches the output register; values are Q16.16 for FRAC_BITS = 16,
// and a basis term with a zero denominator skips the divider and takes a zero quotient.
// The bit-serial divider dominates; the next beat is taken once the result is registered.
// Synchronous active-low reset sets degree 3 and 4 control points and empties the output.
`default_nettype none
module bspline_curve_point_evaluator_unit #(
  parameter int MAX_CONTROL_POINTS = 32,
  parameter int MAX_DEGREE         = 7,
  parameter int FRAC_BITS          = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // index[5:0], value[37:6], point_x[69:38], point_y[101:70], point_z[133:102], zero pad
  input  wire logic [135:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // curve_x[31:0], curve_y[63:32], curve_z[95:64], span[100:96], zero pad
  output logic [103:0]      out_tdata,
  // out_of_range[0]
  output logic              out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [5:0]   cfg_data
);

  bspce_pkg::cmd_t    cmd;
  bspce_pkg::stat_t   stat;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic [4:0]         span;

  assign cfg_ready = 1'b1;

  bspce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_func  (in_tuser),
    .stat     (stat),
    .in_tready(in_tready),
    .cmd      (cmd)
  );

  bspce_dp #(
    .MAX_CONTROL_POINTS(MAX_CONTROL_POINTS),
    .MAX_DEGREE        (MAX_DEGREE),
    .FRAC_BITS         (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_index    (in_tdata[5:0]),
    .in_value    ($signed(in_tdata[37:6])),
    .in_point_x  ($signed(in_tdata[69:38])),
    .in_point_y  ($signed(in_tdata[101:70])),
    .in_point_z  ($signed(in_tdata[133:102])),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_curve_x (cx),
    .out_curve_y (cy),
    .out_curve_z (cz),
    .out_span    (span),
    .out_of_range(out_tuser)
  );

  assign out_tdata = {3'b000, span, cz, cy, cx};

endmodule
`default_nettype wire
